// File: hdl/cstr_pkg.sv
// shared types and constants of the c comment stripper
// no dependencies; imported by the scanner, the result queue and the top level
package cstr_pkg;

    // ascii codes the scanners look for or emit
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // one text byte yields at most three byte results plus the end result
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 8;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       end_of_text;
        logic       unterminated;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]                count;
        t_result [MAX_RESULTS-1:0]       res;
    } t_batch;

endpackage

// File: hdl/cstr_scanner.sv
// line comment and block comment scanners in a chain, one text byte per step
// depends on cstr_pkg
module cstr_scanner (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_text_byte,
    input  logic            i_is_final,
    output cstr_pkg::t_batch o_batch
);
    import cstr_pkg::*;

    localparam int IDX_W = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        LM_NORMAL  = 2'd0,
        LM_HELD    = 2'd1,
        LM_COMMENT = 2'd2
    } t_line_mode;

    typedef enum logic [1:0] {
        BM_NORMAL = 2'd0,
        BM_HELD   = 2'd1,
        BM_BLOCK  = 2'd2,
        BM_STAR   = 2'd3
    } t_block_mode;

    typedef struct packed {
        t_block_mode mode;
        logic [1:0]  n;
        logic [7:0]  b0;
        logic [7:0]  b1;
    } t_bf;

    t_line_mode  r_lm, n_lm;
    t_block_mode r_bm, n_bm;

    function automatic t_bf block_feed(t_block_mode m, logic [7:0] b);
        t_bf r;
        r.mode = m;
        r.n    = 2'd0;
        r.b0   = b;
        r.b1   = b;
        case (m)
            BM_HELD: begin
                if (b == CH_STAR) begin
                    r.mode = BM_BLOCK;
                end else if (b == CH_SLASH) begin
                    r.n  = 2'd1;
                    r.b0 = CH_SLASH;
                end else begin
                    r.n    = 2'd2;
                    r.b0   = CH_SLASH;
                    r.mode = BM_NORMAL;
                end
            end
            BM_BLOCK: begin
                if (b == CH_STAR) r.mode = BM_STAR;
            end
            BM_STAR: begin
                if (b == CH_SLASH) begin
                    r.n    = 2'd1;
                    r.b0   = CH_SPACE;
                    r.mode = BM_NORMAL;
                end else if (b != CH_STAR) begin
                    r.mode = BM_BLOCK;
                end
            end
            default: begin
                if (b == CH_SLASH) r.mode = BM_HELD;
                else               r.n = 2'd1;
            end
        endcase
        return r;
    endfunction

    function automatic t_result byte_result(logic [7:0] b);
        t_result r;
        r.out_byte     = b;
        r.byte_present = 1'b1;
        r.end_of_text  = 1'b0;
        r.unterminated = 1'b0;
        return r;
    endfunction

    logic       feed_en [3];
    logic [7:0] feed_b  [3];
    t_bf        fb;
    logic [CNT_W-1:0] cnt;
    t_result [MAX_RESULTS-1:0] res;
    t_result    end_res;

    always_comb begin
        // line pass: decide which bytes go on to the block pass
        n_lm       = r_lm;
        feed_en[0] = 1'b0;
        feed_b[0]  = i_text_byte;
        feed_en[1] = 1'b0;
        feed_b[1]  = i_text_byte;
        case (r_lm)
            LM_HELD: begin
                if (i_text_byte == CH_SLASH) begin
                    n_lm = LM_COMMENT;
                end else begin
                    feed_en[0] = 1'b1;
                    feed_b[0]  = CH_SLASH;
                    feed_en[1] = 1'b1;
                    n_lm       = LM_NORMAL;
                end
            end
            LM_COMMENT: begin
                if (i_text_byte == CH_NL) begin
                    feed_en[0] = 1'b1;
                    n_lm       = LM_NORMAL;
                end
            end
            default: begin
                if (i_text_byte == CH_SLASH) begin
                    n_lm = LM_HELD;
                end else begin
                    feed_en[0] = 1'b1;
                    n_lm       = LM_NORMAL;
                end
            end
        endcase
        // held slash of the line pass is flushed at end of text
        feed_en[2] = i_is_final && (n_lm == LM_HELD);
        feed_b[2]  = CH_SLASH;

        // block pass over up to three fed bytes
        n_bm = r_bm;
        cnt  = '0;
        res  = '0;
        for (int k = 0; k < 3; k++) begin
            fb = block_feed(n_bm, feed_b[k]);
            if (feed_en[k]) begin
                n_bm = fb.mode;
                if (fb.n != 2'd0) begin
                    res[cnt[IDX_W-1:0]] = byte_result(fb.b0);
                    cnt = cnt + CNT_W'(1);
                end
                if (fb.n == 2'd2) begin
                    res[cnt[IDX_W-1:0]] = byte_result(fb.b1);
                    cnt = cnt + CNT_W'(1);
                end
            end
        end

        end_res              = '0;
        end_res.end_of_text  = 1'b1;
        if (i_is_final) begin
            if (n_bm == BM_HELD) begin
                res[cnt[IDX_W-1:0]] = byte_result(CH_SLASH);
                cnt  = cnt + CNT_W'(1);
                n_bm = BM_NORMAL;
            end
            end_res.unterminated = (n_bm == BM_BLOCK) || (n_bm == BM_STAR);
            res[cnt[IDX_W-1:0]]  = end_res;
            cnt  = cnt + CNT_W'(1);
            n_lm = LM_NORMAL;
            n_bm = BM_NORMAL;
        end

        o_batch.count = cnt;
        o_batch.res   = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lm <= LM_NORMAL;
            r_bm <= BM_NORMAL;
        end else if (i_step) begin
            r_lm <= n_lm;
            r_bm <= n_bm;
        end
    end

endmodule

// File: hdl/cstr_queue.sv
// result queue: takes a batch of up to four results per cycle, hands out one
// depends on cstr_pkg
module cstr_queue #(
    parameter int DEPTH = cstr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  cstr_pkg::t_batch i_batch,
    output logic             o_room,
    output logic             o_valid,
    output cstr_pkg::t_result o_head,
    input  logic             i_pop
);
    import cstr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result          r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic [PW-1:0]    w_idx [MAX_RESULTS+1];
    logic [PW:0]      w_sum [MAX_RESULTS+1];

    // slot addresses for the batch, wrapped around the ring
    always_comb begin
        for (int k = 0; k <= MAX_RESULTS; k++) begin
            w_sum[k] = {1'b0, r_wr_ptr} + (PW+1)'(k);
            if (w_sum[k] >= (PW+1)'(DEPTH)) w_sum[k] = w_sum[k] - (PW+1)'(DEPTH);
            w_idx[k] = w_sum[k][PW-1:0];
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_room  = ({1'b0, r_count} + (CW+1)'(MAX_RESULTS)) <= (CW+1)'(DEPTH);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = w_idx[i_batch.count];
            n_count  = n_count + CW'(i_batch.count);
        end
        if (i_pop && o_valid) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            n_count  = n_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                if (CNT_W'(k) < i_batch.count) r_mem[w_idx[k]] <= i_batch.res[k];
            end
        end
    end

endmodule

// File: hdl/c_comment_stripper.sv
// top level of the c comment stripper: input register, scanner, result queue
// depends on cstr_pkg, cstr_scanner and cstr_queue
//
// Strips C comments from a byte stream. Each text byte enters with i_is_final
// marking the last byte of a text. A line comment is deleted from its double
// slash up to, but not including, the newline (or the end of the text); a
// block comment is replaced by one space, and its opening star never closes
// it. A slash that could open a comment is held and emitted once the next
// byte shows it does not. After the last byte one bare end result follows
// (o_byte_present low, o_end_of_text high) with o_unterminated set when a
// block comment was still open. Rate: one text byte is accepted per cycle
// as long as the result queue has room for four results; each byte yields
// zero to three byte results plus the end result on the final byte, and the
// output side delivers one result per cycle while i_out_ready is held high,
// so the sustained rate is set by the output port at one result per cycle.
// A byte is scanned from the input register once the queue has room, and its
// results are written into the queue at the same edge that advances the
// scanner state, behind any results already queued.
module c_comment_stripper #(
    parameter int QUEUE_DEPTH = cstr_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // text input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_is_final,
    // result output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_present,
    output logic       o_end_of_text,
    output logic       o_unterminated
);
    import cstr_pkg::*;

    // input register: holds one byte until the queue can take its results
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    logic    w_room;
    logic    w_step;
    t_batch  w_batch;
    t_result w_head;

    // the byte in the register is scanned once the queue has room for a
    // full batch; a new transfer can land in the same cycle
    assign w_step     = r_in_valid && w_room;
    assign o_in_ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_text_byte;
            r_in_final <= i_is_final;
        end
    end

    cstr_scanner u_scanner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_text_byte (r_in_byte),
        .i_is_final  (r_in_final),
        .o_batch     (w_batch)
    );

    cstr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_step),
        .i_batch (w_batch),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .o_head  (w_head),
        .i_pop   (i_out_ready)
    );

    assign o_out_byte     = w_head.out_byte;
    assign o_byte_present = w_head.byte_present;
    assign o_end_of_text  = w_head.end_of_text;
    assign o_unterminated = w_head.unterminated;

    // a result is either a byte or the end marker, never both
    a_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_present != o_end_of_text))
        else $error("result is neither a byte nor an end marker");

    // open block comment is only flagged on the end marker
    a_unterm : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unterminated) |-> o_end_of_text)
        else $error("unterminated flag outside the end marker");

    // a held byte that was not scanned stays in the input register
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_step) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input byte lost before it was scanned");

endmodule
